### design/frws_pkg.sv
// ----------------------------------------------------------------------------
// frws_pkg
// shared widths, constants and types of the frame rate window statistics block
// ----------------------------------------------------------------------------
package frws_pkg;

    // window length, a power of two so that the averages are plain shifts
    localparam int WINDOW    = 16;
    localparam int WIN_LOG2  = $clog2(WINDOW);
    localparam int SLOT_W    = (WIN_LOG2 < 1) ? 1 : WIN_LOG2;

    localparam int PERIOD_W      = 24;
    localparam int RATE_W        = 28;
    localparam int RATE_SUM_W    = RATE_W + WIN_LOG2;
    localparam int PERIOD_SUM_W  = PERIOD_W + WIN_LOG2;

    // one second in microseconds with 8 fractional bits
    localparam logic [RATE_W-1:0] RATE_SCALE = RATE_W'(256000000);

    // front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // divider step counter
    localparam int DCNT_W = $clog2(RATE_W);

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] divisor;
    } frws_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUM,
        ST_STAT
    } frws_state_t;

endpackage

### design/frame_rate_window_stats.sv
// ----------------------------------------------------------------------------
// frame_rate_window_stats
// moving average frame rate and frame time with running extremes
// ----------------------------------------------------------------------------
//
// channel | direction | handshake           | payload
// --------+-----------+---------------------+---------------------------------
// in      | request   | in_valid / in_stall | frame_time_us
// out     | result    | out_valid/out_stall | avg_rate min_rate max_rate
//         |           |                     | avg_period min_period max_period
//
// in the back end a request steps through: pop and read the ring slot, the
// bit-serial reciprocal divider, its done strobe, the window sum update and the
// result load, which waits while the result ahead of it is stalled
// the front queue holds two requests, so the input can still take up to two
// while the back end is busy or the result waits on out_stall
// reset clears the queue, the sums, the ring valid bits and the extremes
// (minimums to all ones); no clearing pass is needed
// a stalled result holds; the back end finishes the next request up to the
// result load and waits there
//
module frame_rate_window_stats (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [frws_pkg::PERIOD_W-1:0]    frame_time_us,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [frws_pkg::RATE_W-1:0]      avg_rate,
    output logic [frws_pkg::RATE_W-1:0]      min_rate,
    output logic [frws_pkg::RATE_W-1:0]      max_rate,
    output logic [frws_pkg::PERIOD_W-1:0]    avg_period,
    output logic [frws_pkg::PERIOD_W-1:0]    min_period,
    output logic [frws_pkg::PERIOD_W-1:0]    max_period
);

    // queued request with its clamped divisor
    frws_pkg::frws_item_t    item;
    logic                    item_valid;
    logic                    item_pop;

    // front: accept, clamp a zero frame time to a divisor of one, queue
    frws_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .frame_time_us (frame_time_us),
        .item_valid    (item_valid),
        .item_pop      (item_pop),
        .item          (item)
    );

    // back: reciprocal, ring update, window sums, extremes, result register
    frws_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .avg_rate   (avg_rate),
        .min_rate   (min_rate),
        .max_rate   (max_rate),
        .avg_period (avg_period),
        .min_period (min_period),
        .max_period (max_period)
    );

endmodule

### design/frws_front.sv
// ----------------------------------------------------------------------------
// frws_front
// accepts frame times, clamps the divisor and queues them for the back end
// ----------------------------------------------------------------------------
module frws_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [frws_pkg::PERIOD_W-1:0]    frame_time_us,
    output logic                             item_valid,
    input  logic                             item_pop,
    output frws_pkg::frws_item_t             item
);

    frws_pkg::frws_item_t             queue_mem [frws_pkg::QUEUE_DEPTH];
    logic [frws_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [frws_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [frws_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [frws_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [frws_pkg::QCNT_W-1:0]      count_reg;
    logic [frws_pkg::QCNT_W-1:0]      count_next;
    logic                             push;
    logic                             pop;
    frws_pkg::frws_item_t             new_item;

    assign in_stall   = (count_reg == frws_pkg::QCNT_W'(frws_pkg::QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign push       = in_valid && !in_stall;
    assign pop        = item_pop && item_valid;
    assign item       = queue_mem[rd_ptr_reg];

    // zero frame time divides by one
    always_comb
    begin
        new_item.period  = frame_time_us;
        new_item.divisor = (frame_time_us == '0) ? frws_pkg::PERIOD_W'(1) : frame_time_us;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == frws_pkg::QPTR_W'(frws_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == frws_pkg::QPTR_W'(frws_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

### design/frws_div.sv
// ----------------------------------------------------------------------------
// frws_div
// bit-serial restoring divider for the rate reciprocal, one quotient bit a cycle
// ----------------------------------------------------------------------------
module frws_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [frws_pkg::PERIOD_W-1:0]    divisor,
    output logic                             done,
    output logic [frws_pkg::RATE_W-1:0]      quotient
);

    logic                             busy_reg;
    logic                             busy_next;
    logic                             done_reg;
    logic                             done_next;
    logic [frws_pkg::DCNT_W-1:0]      cnt_reg;
    logic [frws_pkg::DCNT_W-1:0]      cnt_next;
    logic [frws_pkg::PERIOD_W-1:0]    den_reg;
    logic [frws_pkg::PERIOD_W-1:0]    den_next;
    logic [frws_pkg::PERIOD_W-1:0]    rem_reg;
    logic [frws_pkg::PERIOD_W-1:0]    rem_next;
    logic [frws_pkg::RATE_W-1:0]      num_reg;
    logic [frws_pkg::RATE_W-1:0]      num_next;
    logic [frws_pkg::RATE_W-1:0]      quo_reg;
    logic [frws_pkg::RATE_W-1:0]      quo_next;
    logic [frws_pkg::PERIOD_W:0]      trial;
    logic [frws_pkg::PERIOD_W:0]      diff;
    logic                             fits;

    assign trial    = {rem_reg, num_reg[frws_pkg::RATE_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign fits     = (trial >= {1'b0, den_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = frws_pkg::DCNT_W'(frws_pkg::RATE_W - 1);
            den_next  = divisor;
            rem_next  = '0;
            num_next  = frws_pkg::RATE_SCALE;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the top bit drops out
            rem_next = fits ? diff[frws_pkg::PERIOD_W-1:0] : trial[frws_pkg::PERIOD_W-1:0];
            num_next = {num_reg[frws_pkg::RATE_W-2:0], 1'b0};
            quo_next = {quo_reg[frws_pkg::RATE_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

endmodule

### design/frws_back.sv
// ----------------------------------------------------------------------------
// frws_back
// rings, window sums, running extremes and the result register
// ----------------------------------------------------------------------------
module frws_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_pop,
    input  frws_pkg::frws_item_t             item,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [frws_pkg::RATE_W-1:0]      avg_rate,
    output logic [frws_pkg::RATE_W-1:0]      min_rate,
    output logic [frws_pkg::RATE_W-1:0]      max_rate,
    output logic [frws_pkg::PERIOD_W-1:0]    avg_period,
    output logic [frws_pkg::PERIOD_W-1:0]    min_period,
    output logic [frws_pkg::PERIOD_W-1:0]    max_period
);

    frws_pkg::frws_state_t                state_reg;
    frws_pkg::frws_state_t                state_next;

    logic [frws_pkg::RATE_W-1:0]          rate_ring [frws_pkg::WINDOW];
    logic [frws_pkg::PERIOD_W-1:0]        period_ring [frws_pkg::WINDOW];
    logic [frws_pkg::WINDOW-1:0]          ring_valid_reg;
    logic [frws_pkg::SLOT_W-1:0]          slot_reg;
    logic [frws_pkg::RATE_W-1:0]          old_rate_reg;
    logic [frws_pkg::PERIOD_W-1:0]        old_period_reg;
    logic [frws_pkg::PERIOD_W-1:0]        period_reg;
    logic [frws_pkg::RATE_SUM_W-1:0]      rate_sum_reg;
    logic [frws_pkg::RATE_SUM_W-1:0]      rate_sum_next;
    logic [frws_pkg::PERIOD_SUM_W-1:0]    period_sum_reg;
    logic [frws_pkg::PERIOD_SUM_W-1:0]    period_sum_next;
    logic [frws_pkg::RATE_W-1:0]          rate_low_reg;
    logic [frws_pkg::RATE_W-1:0]          rate_high_reg;
    logic [frws_pkg::PERIOD_W-1:0]        period_low_reg;
    logic [frws_pkg::PERIOD_W-1:0]        period_high_reg;
    logic [frws_pkg::RATE_W-1:0]          avg_rate_reg;
    logic [frws_pkg::PERIOD_W-1:0]        avg_period_reg;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [frws_pkg::RATE_W-1:0]          avg_r;
    logic [frws_pkg::PERIOD_W-1:0]        avg_p;

    logic                                 div_start;
    logic                                 div_done;
    logic [frws_pkg::RATE_W-1:0]          div_quo;
    logic                                 sum_en;
    logic                                 load_en;
    logic                                 out_free;

    frws_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (item.divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            frws_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = frws_pkg::ST_DIV;
                end
            end
            frws_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = frws_pkg::ST_SUM;
                end
            end
            frws_pkg::ST_SUM:
            begin
                state_next = frws_pkg::ST_STAT;
            end
            frws_pkg::ST_STAT:
            begin
                if (out_free)
                begin
                    state_next = frws_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = frws_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        item_pop  = 1'b0;
        div_start = 1'b0;
        sum_en    = 1'b0;
        load_en   = 1'b0;
        case (state_reg)
            frws_pkg::ST_IDLE:
            begin
                item_pop  = item_valid;
                div_start = item_valid;
            end
            frws_pkg::ST_DIV:
            begin
            end
            frws_pkg::ST_SUM:
            begin
                sum_en = 1'b1;
            end
            frws_pkg::ST_STAT:
            begin
                load_en = out_free;
            end
            default:
            begin
            end
        endcase
    end

    assign rate_sum_next   = rate_sum_reg - frws_pkg::RATE_SUM_W'(old_rate_reg)
                           + frws_pkg::RATE_SUM_W'(div_quo);
    assign period_sum_next = period_sum_reg - frws_pkg::PERIOD_SUM_W'(old_period_reg)
                           + frws_pkg::PERIOD_SUM_W'(period_reg);

    assign avg_r = rate_sum_reg[frws_pkg::WIN_LOG2 +: frws_pkg::RATE_W];
    assign avg_p = period_sum_reg[frws_pkg::WIN_LOG2 +: frws_pkg::PERIOD_W];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= frws_pkg::ST_IDLE;
            ring_valid_reg  <= '0;
            slot_reg        <= '0;
            rate_sum_reg    <= '0;
            period_sum_reg  <= '0;
            rate_low_reg    <= '1;
            rate_high_reg   <= '0;
            period_low_reg  <= '1;
            period_high_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (sum_en)
            begin
                rate_sum_reg             <= rate_sum_next;
                period_sum_reg           <= period_sum_next;
                ring_valid_reg[slot_reg] <= 1'b1;
                slot_reg <= (slot_reg == frws_pkg::SLOT_W'(frws_pkg::WINDOW - 1))
                          ? '0 : slot_reg + 1'b1;
            end
            if (load_en)
            begin
                if (avg_r < rate_low_reg)
                begin
                    rate_low_reg <= avg_r;
                end
                if (avg_r > rate_high_reg)
                begin
                    rate_high_reg <= avg_r;
                end
                if (avg_p < period_low_reg)
                begin
                    period_low_reg <= avg_p;
                end
                if (avg_p > period_high_reg)
                begin
                    period_high_reg <= avg_p;
                end
            end
        end
    end

    // ring storage, registered read of the slot about to be replaced
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            period_reg     <= item.period;
            old_rate_reg   <= ring_valid_reg[slot_reg] ? rate_ring[slot_reg] : '0;
            old_period_reg <= ring_valid_reg[slot_reg] ? period_ring[slot_reg] : '0;
        end
        if (sum_en)
        begin
            rate_ring[slot_reg]   <= div_quo;
            period_ring[slot_reg] <= period_reg;
        end
        if (load_en)
        begin
            avg_rate_reg   <= avg_r;
            avg_period_reg <= avg_p;
        end
    end

    assign out_valid  = out_valid_reg;
    assign avg_rate   = avg_rate_reg;
    assign min_rate   = rate_low_reg;
    assign max_rate   = rate_high_reg;
    assign avg_period = avg_period_reg;
    assign min_period = period_low_reg;
    assign max_period = period_high_reg;

endmodule

### dv/tb_frame_rate_window_stats.sv
// ----------------------------------------------------------------------------
// tb_frame_rate_window_stats
// self-checking bench for the moving average frame rate and frame time block
//
// frame times go in through a valid/stall channel. Every accepted request is
// run through a local model of the two rings, the window sums and the running
// extremes. The expected six-field result is queued and compared with each
// accepted result in order. A short table of directed frame times comes
// first. Random frame times follow in three idle phases, with one long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_frame_rate_window_stats;

    timeunit 1ns;
    timeprecision 1ps;

    import frws_pkg::*;

    // bench constants
    localparam int          NUM_DIRECTED     = 20;
    localparam int          ITEMS_PER_PHASE  = 560;
    localparam int          HOLD_OFF_CYCLES  = 800;
    localparam int          DRAIN_CYCLES     = 64;
    localparam int          STUCK_LIMIT      = 4000;
    localparam logic [31:0] ONE_SECOND_Q8    = 32'd256000000;
    localparam int          RATE_TOTAL_W     = RATE_W + 8;    // wide enough for a window of 256
    localparam int          PERIOD_TOTAL_W   = PERIOD_W + 8;

    // one result of the block, in port order
    typedef struct packed {
        logic [RATE_W-1:0]   avg_rate;
        logic [RATE_W-1:0]   min_rate;
        logic [RATE_W-1:0]   max_rate;
        logic [PERIOD_W-1:0] avg_period;
        logic [PERIOD_W-1:0] min_period;
        logic [PERIOD_W-1:0] max_period;
    } window_stats_t;

    // one row of the directed table; known rows carry a typed-in result
    typedef struct packed {
        logic [PERIOD_W-1:0] frame_time;
        logic                known;
        window_stats_t       want;
    } directed_row_t;

    localparam window_stats_t NO_WANT = '0;

    // dut ports, all inputs at known values from time zero
    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [PERIOD_W-1:0] frame_time_us = '0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic [RATE_W-1:0]   avg_rate;
    logic [RATE_W-1:0]   min_rate;
    logic [RATE_W-1:0]   max_rate;
    logic [PERIOD_W-1:0] avg_period;
    logic [PERIOD_W-1:0] min_period;
    logic [PERIOD_W-1:0] max_period;

    // local copy of the block state for prediction
    logic [RATE_W-1:0]         rate_hist   [WINDOW];
    logic [PERIOD_W-1:0]       period_hist [WINDOW];
    logic [RATE_TOTAL_W-1:0]   rate_total;
    logic [PERIOD_TOTAL_W-1:0] period_total;
    logic [SLOT_W-1:0]         hist_pos;
    logic [RATE_W-1:0]         rate_floor;
    logic [RATE_W-1:0]         rate_peak;
    logic [PERIOD_W-1:0]       period_floor;
    logic [PERIOD_W-1:0]       period_peak;

    // results still owed by the block, oldest first
    window_stats_t       stats_due [$];
    directed_row_t       directed_rows [NUM_DIRECTED];

    int                  mismatches     = 0;
    int                  send_idle_pct  = 0;
    int                  recv_idle_pct  = 0;
    int                  stuck_cycles   = 0;
    logic                hold_off_req   = 1'b0;

    frame_rate_window_stats u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .frame_time_us (frame_time_us),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .avg_rate      (avg_rate),
        .min_rate      (min_rate),
        .max_rate      (max_rate),
        .avg_period    (avg_period),
        .min_period    (min_period),
        .max_period    (max_period)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // advance the local window by one frame time and return the new result
    function automatic window_stats_t predict_window_stats(
        input logic [PERIOD_W-1:0] frame_time
    );
        logic [PERIOD_W-1:0] divisor;
        logic [RATE_W-1:0]   rate;
        window_stats_t       stats;
        // zero frame time divides by one, giving the full scale rate
        divisor = (frame_time == '0) ? PERIOD_W'(1) : frame_time;
        rate    = RATE_W'(ONE_SECOND_Q8 / 32'(divisor));

        // swap the oldest entry out of both running sums
        rate_total            = rate_total - RATE_TOTAL_W'(rate_hist[hist_pos])
                              + RATE_TOTAL_W'(rate);
        rate_hist[hist_pos]   = rate;
        period_total          = period_total - PERIOD_TOTAL_W'(period_hist[hist_pos])
                              + PERIOD_TOTAL_W'(frame_time);
        period_hist[hist_pos] = frame_time;

        stats.avg_rate   = RATE_W'(rate_total / RATE_TOTAL_W'(WINDOW));
        stats.avg_period = PERIOD_W'(period_total / PERIOD_TOTAL_W'(WINDOW));

        if (stats.avg_rate < rate_floor)     rate_floor   = stats.avg_rate;
        if (stats.avg_rate > rate_peak)      rate_peak    = stats.avg_rate;
        if (stats.avg_period < period_floor) period_floor = stats.avg_period;
        if (stats.avg_period > period_peak)  period_peak  = stats.avg_period;

        stats.min_rate   = rate_floor;
        stats.max_rate   = rate_peak;
        stats.min_period = period_floor;
        stats.max_period = period_peak;

        // ring index wraps with no slot skipped
        hist_pos = (hist_pos == SLOT_W'(WINDOW - 1)) ? '0 : hist_pos + 1'b1;
        return stats;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // offer one request, with a random gap first, and queue its result
    // entered at the edge where the previous request went in (or after reset)
    task automatic send_frame(input logic [PERIOD_W-1:0] frame_time, input logic known,
                              input window_stats_t want);
        window_stats_t predicted;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid      <= 1'b1;
        frame_time_us <= frame_time;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge; the model always advances
        predicted = predict_window_stats(frame_time);
        stats_due.push_back(known ? want : predicted);
    endtask

    // receiver: random stall each cycle, plus one long hold-off on request
    initial
    begin : receiver
        bit hold_taken;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_taken)
            begin
                // hold the output for a long stretch so the front queue fills
                // and the block has to stall its input
                hold_taken = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // result checker: every accepted result against the oldest expectation
    always @(posedge clk)
    begin : result_check
        window_stats_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (stats_due.size() == 0)
            begin
                $display("%0t: result with no request outstanding, avg_rate %0d",
                         $time, avg_rate);
                mismatches++;
            end
            else
            begin
                want = stats_due.pop_front();
                check_field("avg_rate",   32'(want.avg_rate),   32'(avg_rate));
                check_field("min_rate",   32'(want.min_rate),   32'(min_rate));
                check_field("max_rate",   32'(want.max_rate),   32'(max_rate));
                check_field("avg_period", 32'(want.avg_period), 32'(avg_period));
                check_field("min_period", 32'(want.min_period), 32'(min_period));
                check_field("max_period", 32'(want.max_period), 32'(max_period));
            end
        end
    end

    // watchdog: ends the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: watchdog, nothing moved for %0d cycles, %0d results owed",
                     $time, stuck_cycles, stats_due.size());
            $display("*** FAILED ***");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // main sequence
    initial
    begin : stimulus
        logic [PERIOD_W-1:0] frame_time;
        int                  pick;
        int                  run;
        int                  sent;

        // model state right after reset: cleared rings, minimums at all ones
        rate_hist    = '{default: '0};
        period_hist  = '{default: '0};
        rate_total   = '0;
        period_total = '0;
        hist_pos     = '0;
        rate_floor   = '1;
        rate_peak    = '0;
        period_floor = '1;
        period_peak  = '0;

        // directed table
        // first row after reset: zero frame time, full scale rate over a zero ring
        directed_rows[0]  = {24'd0,        1'b1, 28'd16000000, 28'd16000000, 28'd16000000,
                             24'd0, 24'd0, 24'd0};
        // longest frame time: rate 15, period sum 0xffffff
        directed_rows[1]  = {24'hFFFFFF,   1'b1, 28'd16000000, 28'd16000000, 28'd16000000,
                             24'd1048575, 24'd0, 24'd1048575};
        directed_rows[2]  = {24'd1,        1'b0, NO_WANT};
        directed_rows[3]  = {24'd2,        1'b0, NO_WANT};
        directed_rows[4]  = {24'd3,        1'b0, NO_WANT};
        directed_rows[5]  = {24'd255,      1'b0, NO_WANT};
        directed_rows[6]  = {24'd256,      1'b0, NO_WANT};
        directed_rows[7]  = {24'd1000,     1'b0, NO_WANT};
        directed_rows[8]  = {24'd16667,    1'b0, NO_WANT};
        directed_rows[9]  = {24'd33333,    1'b0, NO_WANT};
        directed_rows[10] = {24'h800000,   1'b0, NO_WANT};
        directed_rows[11] = {24'h7FFFFF,   1'b0, NO_WANT};
        directed_rows[12] = {24'hAAAAAA,   1'b0, NO_WANT};
        directed_rows[13] = {24'h555555,   1'b0, NO_WANT};
        directed_rows[14] = {24'd256000,   1'b0, NO_WANT};
        directed_rows[15] = {24'd0,        1'b0, NO_WANT};
        // rows from here on land on reused ring slots after the wrap
        directed_rows[16] = {24'hFFFFFF,   1'b0, NO_WANT};
        directed_rows[17] = {24'd1,        1'b0, NO_WANT};
        directed_rows[18] = {24'hFFFFFE,   1'b0, NO_WANT};
        directed_rows[19] = {24'd100000,   1'b0, NO_WANT};

        // reset held once at the start, then released
        send_idle_pct = 30;
        recv_idle_pct = 63;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_frame(directed_rows[i].frame_time, directed_rows[i].known,
                       directed_rows[i].want);

        // random part in three idle phases
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 30;
                    recv_idle_pct = 63;
                end
                1:
                begin
                    send_idle_pct = 63;
                    recv_idle_pct = 30;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_off_req  = 1'b1;   // sender keeps offering meanwhile
                end
            endcase

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(99);
                run  = 1;
                if (pick < 45)
                    frame_time = PERIOD_W'($urandom_range(100000, 4000));   // real frame rates
                else if (pick < 60)
                    frame_time = PERIOD_W'($urandom_range(300, 0));         // very short frames
                else if (pick < 78)
                    frame_time = PERIOD_W'($urandom());                     // any 24-bit value
                else if (pick < 88)
                begin
                    case ($urandom_range(3))
                        0:       frame_time = '0;
                        1:       frame_time = PERIOD_W'(1);
                        2:       frame_time = '1;
                        default: frame_time = '1 - PERIOD_W'(1);
                    endcase
                end
                else
                begin
                    // a window's worth of one extreme drives the averages to their limits
                    frame_time = $urandom_range(1) ? '1 : PERIOD_W'($urandom_range(1, 0));
                    run        = $urandom_range(WINDOW + 4, WINDOW);
                end
                repeat (run) send_frame(frame_time, 1'b0, NO_WANT);
                sent += run;
            end
        end
        in_valid <= 1'b0;

        // drain, then let the back end settle
        while (stats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && stats_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
